### src/pps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_pkg
// shared constants and types for the point projection pipeline
// ----------------------------------------------------------------------------
package pps_pkg;
    localparam int NUM_REGS   = 8;
    localparam int IDX_W      = 3;
    localparam int CFG_W      = 64;
    localparam int Q_W        = 32;
    // three floored products of up to 47 bits plus a 32-bit constant
    localparam int CLIP_W     = 50;
    // divider: 31-bit quotient magnitude, two bits per stage
    localparam int DIV_QBITS  = 32;
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = DIV_QBITS / DIV_STEP;

    localparam logic [IDX_W-1:0] REG_FROM_X    = 3'd0;
    localparam logic [IDX_W-1:0] REG_FROM_Y    = 3'd1;
    localparam logic [IDX_W-1:0] REG_FROM_Z    = 3'd2;
    localparam logic [IDX_W-1:0] REG_TRANSLATE = 3'd3;
    localparam logic [IDX_W-1:0] REG_W_XY      = 3'd4;
    localparam logic [IDX_W-1:0] REG_W_ZT      = 3'd5;
    localparam logic [IDX_W-1:0] REG_VP_DIMS   = 3'd6;
    localparam logic [IDX_W-1:0] REG_VP_OFFSET = 3'd7;

    typedef struct packed {
        logic signed [CLIP_W-1:0] cx;
        logic signed [CLIP_W-1:0] cy;
        logic signed [CLIP_W-1:0] cw;
    } t_clip;
endpackage

### src/pps_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_div
// pipelined restoring divider, two quotient bits per stage, with stall
// ----------------------------------------------------------------------------
module pps_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [pps_pkg::CLIP_W-1:0]  i_num,    // magnitude
    input  logic [pps_pkg::CLIP_W-1:0]  i_den,    // magnitude, nonzero
    output logic                        o_valid,
    output logic [pps_pkg::DIV_QBITS-1:0] o_quo,
    output logic                        o_ovf
);
    import pps_pkg::*;
    // dividend is num*2^16 (up to 66 bits); quotient limited to 32 bits:
    // overflow test first, then 32 bits of long division seeded with the
    // upper dividend bits, which are below the divisor when there is no overflow
    localparam int RW = CLIP_W + 1;
    localparam int NW = CLIP_W + 16;

    logic [DIV_STAGES:0]         r_v;
    logic [RW-1:0]               r_rem [DIV_STAGES+1];
    logic [DIV_QBITS-1:0]        r_num [DIV_STAGES+1];
    logic [CLIP_W-1:0]           r_den [DIV_STAGES+1];
    logic [DIV_QBITS-1:0]        r_q   [DIV_STAGES+1];
    logic [DIV_STAGES:0]         r_ovf;

    logic [NW-1:0] w_n;
    assign w_n = {i_num, 16'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[DIV_STAGES-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= w_n[DIV_QBITS-1:0];
            r_den[0] <= i_den;
            r_rem[0] <= RW'(w_n[NW-1:DIV_QBITS]);
            r_q[0]   <= '0;
            // quotient >= 2^31 means saturate (q>=0x8000 in integer part)
            r_ovf[0] <= (CLIP_W'(w_n[NW-1:DIV_QBITS-1]) >= i_den);
        end
    end

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_st
        logic [RW-1:0]       n_rem;
        logic [DIV_QBITS-1:0] n_q;
        always_comb begin
            logic [RW-1:0] t;
            n_rem = r_rem[s];
            n_q   = r_q[s];
            for (int b = 0; b < DIV_STEP; b++) begin
                t = {n_rem[RW-2:0],
                     r_num[s][DIV_QBITS-1-s*DIV_STEP-b]};
                n_q = {n_q[DIV_QBITS-2:0], 1'b0};
                if (t >= {1'b0, r_den[s]}) begin
                    n_rem  = t - {1'b0, r_den[s]};
                    n_q[0] = 1'b1;
                end else begin
                    n_rem = t;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= n_rem;
                r_q[s+1]   <= n_q;
                r_num[s+1] <= r_num[s];
                r_den[s+1] <= r_den[s];
                r_ovf[s+1] <= r_ovf[s];
            end
        end
    end

    assign o_valid = r_v[DIV_STAGES];
    assign o_quo   = r_q[DIV_STAGES];
    assign o_ovf   = r_ovf[DIV_STAGES];
endmodule

### src/point_projection_to_screen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_projection_to_screen
// world point to screen position, fixed-point view-projection and viewport map
// ----------------------------------------------------------------------------
// Takes one Q16.16 world point per beat and returns one screen position per
// beat. The block accepts a new point every clock while the output is not
// stalled; each result passes through 22 register stages (2 multiply/sum
// stages, 17 divider stages of which the first takes magnitudes and tests for
// overflow, then ndc, viewport multiply and output stages), most of them in
// the pipelined divider that retires two quotient bits per stage. A stall on
// the output freezes the whole pipe, so nothing is lost.
// Configuration is written through a separate index/data channel, always ready.
module point_projection_to_screen (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // world_x, world_y, world_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // screen_x, screen_y
    output logic        m_axis_tuser,   // w_was_zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [pps_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [pps_pkg::CFG_W-1:0] i_cfg_data
);
    import pps_pkg::*;

    logic [CFG_W-1:0] r_cfg [NUM_REGS];
    logic w_en;

    assign o_cfg_ready = 1'b1;
    // pipe advances unless the output beat is held
    assign w_en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[REG_FROM_X]    <= 64'd65536;
            r_cfg[REG_FROM_Y]    <= 64'd65536 << 32;
            r_cfg[REG_FROM_Z]    <= '0;
            r_cfg[REG_TRANSLATE] <= '0;
            r_cfg[REG_W_XY]      <= '0;
            r_cfg[REG_W_ZT]      <= 64'd65536 << 32;
            r_cfg[REG_VP_DIMS]   <= 64'd47187200;
            r_cfg[REG_VP_OFFSET] <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_VP_DIMS, REG_VP_OFFSET:
                    r_cfg[i_cfg_index] <= {32'd0, i_cfg_data[31:0]};
                default:
                    r_cfg[i_cfg_index] <= i_cfg_data;
            endcase
        end
    end

    function automatic logic signed [31:0] lo(input logic [63:0] v);
        return signed'(v[31:0]);
    endfunction
    function automatic logic signed [31:0] hi(input logic [63:0] v);
        return signed'(v[63:32]);
    endfunction

    // ---- stage 1: nine products, floor to Q16.16 (arith shift is floor)
    logic signed [31:0] w_x, w_y, w_z;
    assign w_x = signed'(s_axis_tdata[31:0]);
    assign w_y = signed'(s_axis_tdata[63:32]);
    assign w_z = signed'(s_axis_tdata[95:64]);

    logic               r1_v;
    logic signed [47:0] r1_p [9];
    logic signed [31:0] r1_tx, r1_ty, r1_tw;
    logic signed [63:0] n1_p [9];

    always_comb begin
        n1_p[0] = lo(r_cfg[REG_FROM_X]) * w_x;
        n1_p[1] = lo(r_cfg[REG_FROM_Y]) * w_y;
        n1_p[2] = lo(r_cfg[REG_FROM_Z]) * w_z;
        n1_p[3] = hi(r_cfg[REG_FROM_X]) * w_x;
        n1_p[4] = hi(r_cfg[REG_FROM_Y]) * w_y;
        n1_p[5] = hi(r_cfg[REG_FROM_Z]) * w_z;
        n1_p[6] = lo(r_cfg[REG_W_XY]) * w_x;
        n1_p[7] = hi(r_cfg[REG_W_XY]) * w_y;
        n1_p[8] = lo(r_cfg[REG_W_ZT]) * w_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (w_en) r1_v <= s_axis_tvalid;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 9; k++) r1_p[k] <= n1_p[k][63:16];
            r1_tx <= lo(r_cfg[REG_TRANSLATE]);
            r1_ty <= hi(r_cfg[REG_TRANSLATE]);
            r1_tw <= hi(r_cfg[REG_W_ZT]);
        end
    end

    // ---- stage 2: clip sums (exact, 50 bits hold 3 x 2^46 + 2^31)
    logic  r2_v;
    t_clip r2_c;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (w_en) r2_v <= r1_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_c.cx <= CLIP_W'(r1_p[0]) + CLIP_W'(r1_p[1]) + CLIP_W'(r1_p[2]) + CLIP_W'(r1_tx);
            r2_c.cy <= CLIP_W'(r1_p[3]) + CLIP_W'(r1_p[4]) + CLIP_W'(r1_p[5]) + CLIP_W'(r1_ty);
            r2_c.cw <= CLIP_W'(r1_p[6]) + CLIP_W'(r1_p[7]) + CLIP_W'(r1_p[8]) + CLIP_W'(r1_tw);
        end
    end

    // ---- stage 3..: magnitudes into two dividers, side data in a delay line
    function automatic logic [CLIP_W-1:0] mag(input logic signed [CLIP_W-1:0] v);
        return v[CLIP_W-1] ? CLIP_W'(-v) : CLIP_W'(v);
    endfunction
    function automatic logic signed [31:0] sat(input logic signed [CLIP_W-1:0] v);
        if (v > CLIP_W'(32'sh7fffffff)) return 32'sh7fffffff;
        if (v < -CLIP_W'(64'sh80000000)) return 32'sh80000000;
        return v[31:0];
    endfunction

    logic [CLIP_W-1:0] w_den;
    logic              w_wz;
    assign w_wz  = (r2_c.cw == '0);
    assign w_den = w_wz ? CLIP_W'(1) : mag(r2_c.cw);

    localparam int DL = DIV_STAGES + 1;
    logic               r_dwz  [DL];
    logic               r_dnx  [DL];
    logic               r_dny  [DL];
    logic signed [31:0] r_dsx  [DL];
    logic signed [31:0] r_dsy  [DL];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dwz[0] <= w_wz;
            r_dnx[0] <= r2_c.cx[CLIP_W-1] ^ r2_c.cw[CLIP_W-1];
            r_dny[0] <= r2_c.cy[CLIP_W-1] ^ r2_c.cw[CLIP_W-1];
            r_dsx[0] <= sat(r2_c.cx);
            r_dsy[0] <= sat(r2_c.cy);
            for (int k = 1; k < DL; k++) begin
                r_dwz[k] <= r_dwz[k-1];
                r_dnx[k] <= r_dnx[k-1];
                r_dny[k] <= r_dny[k-1];
                r_dsx[k] <= r_dsx[k-1];
                r_dsy[k] <= r_dsy[k-1];
            end
        end
    end

    logic                 w_dvx, w_dvy, w_ovx, w_ovy;
    logic [DIV_QBITS-1:0] w_qx, w_qy;

    pps_div u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r2_v),
        .i_num(mag(r2_c.cx)), .i_den(w_den),
        .o_valid(w_dvx), .o_quo(w_qx), .o_ovf(w_ovx)
    );
    pps_div u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r2_v),
        .i_num(mag(r2_c.cy)), .i_den(w_den),
        .o_valid(w_dvy), .o_quo(w_qy), .o_ovf(w_ovy)
    );

    // ---- signed ndc after divide or zero-w bypass
    function automatic logic signed [31:0] ndc(input logic wz, input logic neg,
        input logic ovf, input logic [31:0] q, input logic signed [31:0] s);
        if (wz) return s;
        if (ovf) return neg ? 32'sh80000000 : 32'sh7fffffff;
        return neg ? -signed'(q) : signed'(q);
    endfunction

    logic               r4_v, r4_wz;
    logic signed [32:0] r4_ax, r4_ay;   // ndc_x + 1 and 1 - ndc_y
    logic signed [31:0] w_nx, w_ny;
    assign w_nx = ndc(r_dwz[DL-1], r_dnx[DL-1], w_ovx, w_qx, r_dsx[DL-1]);
    assign w_ny = ndc(r_dwz[DL-1], r_dny[DL-1], w_ovy, w_qy, r_dsy[DL-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (w_en) r4_v <= w_dvx;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_wz <= r_dwz[DL-1];
            r4_ax <= 33'(w_nx) + 33'sd65536;
            r4_ay <= 33'sd65536 - 33'(w_ny);
        end
    end

    // ---- viewport multiply, then halve, add origin, saturate
    logic               r5_v, r5_wz;
    logic signed [49:0] r5_mx, r5_my;
    logic signed [15:0] r5_ox, r5_oy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (w_en) r5_v <= r4_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_wz <= r4_wz;
            r5_mx <= r4_ax * signed'({1'b0, r_cfg[REG_VP_DIMS][15:0]});
            r5_my <= r4_ay * signed'({1'b0, r_cfg[REG_VP_DIMS][31:16]});
            r5_ox <= signed'(r_cfg[REG_VP_OFFSET][15:0]);
            r5_oy <= signed'(r_cfg[REG_VP_OFFSET][31:16]);
        end
    end

    // origin is a signed pixel count, moved to Q16.16
    logic signed [CLIP_W+14:0] w_sx, w_sy;
    assign w_sx = (CLIP_W+15)'(r5_mx >>> 1) + (CLIP_W+15)'(signed'({r5_ox, 16'd0}));
    assign w_sy = (CLIP_W+15)'(r5_my >>> 1) + (CLIP_W+15)'(signed'({r5_oy, 16'd0}));

    function automatic logic signed [31:0] sat50(input logic signed [CLIP_W+14:0] v);
        if (v > (CLIP_W+15)'(32'sh7fffffff)) return 32'sh7fffffff;
        if (v < -(CLIP_W+15)'(64'sh80000000)) return 32'sh80000000;
        return v[31:0];
    endfunction

    // ---- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tvalid <= 1'b0;
        else if (w_en) m_axis_tvalid <= r5_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            m_axis_tdata <= {sat50(w_sy), sat50(w_sx)};
            m_axis_tuser <= r5_wz;
        end
    end

`ifndef SYNTHESIS
    a_div_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dvx == w_dvy) else $error("divider lanes out of step");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("held beat changed");
    a_wz_ndc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dwz[DL-1] |-> w_nx == r_dsx[DL-1]) else $error("zero-w bypass broken");
`endif
endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the world-to-screen point projector
// ----------------------------------------------------------------------------
// Points are streamed in with random gaps while the screen side stalls at
// random. A bit-exact projection model predicts every screen position and a
// small scoreboard compares each output beat in order. The register set is
// rewritten between phases, extremes included.
module tb_top;
    import pps_pkg::*;

    typedef struct {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic               wz;
    } t_screen_pos;

    // ------------------------------------------------------------------
    // in-order store of expected screen positions
    // ------------------------------------------------------------------
    class screen_scoreboard;
        t_screen_pos pending[$];
        int          errors;

        function void note_point(t_screen_pos p);
            pending.push_back(p);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_pos(logic [63:0] data, logic wz);
            t_screen_pos e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected beat %h/%b", data, wz));
                return;
            end
            e = pending.pop_front();
            if (data[31:0] !== e.sx || data[63:32] !== e.sy || wz !== e.wz) begin
                report($sformatf("got sx=%h sy=%h wz=%b exp sx=%h sy=%h wz=%b",
                                 data[31:0], data[63:32], wz, e.sx, e.sy, e.wz));
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    logic [CFG_W-1:0] proj_regs[NUM_REGS];
    screen_scoreboard sb;
    int  idle_pct_in = 34;
    int  idle_pct_out = 34;
    bit  hold_off = 1'b0;
    longint cycle_cnt = 0;

    always #4 i_clk = ~i_clk;

    point_projection_to_screen DUT (.*);

    function automatic longint sat_q(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // floor of the Q32.32 product back to Q16.16 (>>> floors)
    function automatic longint fix_mul(logic [31:0] c, logic [31:0] v);
        longint p;
        p = longint'(signed'(c)) * longint'(signed'(v));
        return p >>> 16;
    endfunction

    // truncated Q16.16 quotient, saturated
    function automatic longint fix_div(longint n, longint d);
        bit neg;
        logic [127:0] un, ud, q;
        neg = (n < 0) != (d < 0);
        un = n < 0 ? -n : n;
        ud = d < 0 ? -d : d;
        q = (un << 16) / ud;
        if (q >= 128'h8000_0000) return neg ? -64'sd2147483648 : 64'sd2147483647;
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic t_screen_pos project_point(logic [95:0] d);
        logic [31:0] x, y, z;
        longint cx, cy, cw, nx, ny, w, h, ox, oy;
        t_screen_pos r;
        x = d[31:0]; y = d[63:32]; z = d[95:64];
        cx = fix_mul(proj_regs[REG_FROM_X][31:0], x) + fix_mul(proj_regs[REG_FROM_Y][31:0], y)
           + fix_mul(proj_regs[REG_FROM_Z][31:0], z)
           + longint'(signed'(proj_regs[REG_TRANSLATE][31:0]));
        cy = fix_mul(proj_regs[REG_FROM_X][63:32], x) + fix_mul(proj_regs[REG_FROM_Y][63:32], y)
           + fix_mul(proj_regs[REG_FROM_Z][63:32], z)
           + longint'(signed'(proj_regs[REG_TRANSLATE][63:32]));
        cw = fix_mul(proj_regs[REG_W_XY][31:0], x) + fix_mul(proj_regs[REG_W_XY][63:32], y)
           + fix_mul(proj_regs[REG_W_ZT][31:0], z)
           + longint'(signed'(proj_regs[REG_W_ZT][63:32]));
        r.wz = (cw == 0);
        if (r.wz) begin
            nx = sat_q(cx);
            ny = sat_q(cy);
        end else begin
            nx = fix_div(cx, cw);
            ny = fix_div(cy, cw);
        end
        w  = proj_regs[REG_VP_DIMS][15:0];
        h  = proj_regs[REG_VP_DIMS][31:16];
        ox = longint'(signed'(proj_regs[REG_VP_OFFSET][15:0]));
        oy = longint'(signed'(proj_regs[REG_VP_OFFSET][31:16]));
        r.sx = 32'(sat_q((((nx + 65536) * w) >>> 1) + ox * 65536));
        r.sy = 32'(sat_q((((65536 - ny) * h) >>> 1) + oy * 65536));
        return r;
    endfunction

    // one write beat, then the register channel goes quiet before the task returns
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        proj_regs[idx] = (idx >= REG_VP_DIMS) ? {32'd0, val[31:0]} : val;
        @(posedge i_clk);
    endtask

    // valid stays high into the next beat unless an idle cycle is drawn
    task automatic send_point(logic [95:0] d);
        while ($urandom_range(99) < idle_pct_in) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_point(project_point(d));
    endtask

    // waits for the pipe to drain so registers can be rewritten safely
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_q();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return $urandom_range(131072) - 65536;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_coord();
        return ($urandom_range(3) == 0) ? rand_q() : ($urandom_range(2000000) - 1000000);
    endfunction

    // screen side: random stalls plus a requested long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_pos(m_axis_tdata, m_axis_tuser);
            m_axis_tready <= !hold_off && ($urandom_range(99) >= idle_pct_out);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 400000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        logic [95:0] pt;
        sb = new();
        for (int i = 0; i < NUM_REGS; i++) proj_regs[i] = '0;
        proj_regs[REG_FROM_X]  = 64'd65536;
        proj_regs[REG_FROM_Y]  = 64'd65536 << 32;
        proj_regs[REG_W_ZT]    = 64'd65536 << 32;
        proj_regs[REG_VP_DIMS] = 64'd47187200;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset registers, field extremes
        send_point('0);
        send_point({32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
        send_point({32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        send_point({32'h0, 32'hffff_0000, 32'h0001_0000});
        drain();
        // perspective setup with w from x, y and z, zero w at the origin
        write_reg(REG_W_ZT, {32'd0, 32'h0001_0000});
        write_reg(REG_FROM_Z, {32'h0000_8000, 32'hffff_8000});
        write_reg(REG_TRANSLATE, {32'h0002_0000, 32'hfffe_0000});
        write_reg(REG_W_XY, {32'h0000_1000, 32'hffff_f000});
        write_reg(REG_VP_OFFSET, {16'h8000, 16'h7fff});
        send_point('0);
        send_point({32'h0000_0001, 32'h0, 32'h0});
        send_point({32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000});
        send_point({32'h0000_0100, 32'h0001_0000, 32'h0001_0000});
        drain();
        // zero viewport and maximum viewport
        write_reg(REG_VP_DIMS, 64'd0);
        send_point({32'h0003_0000, 32'h1234_5678, 32'h8765_4321});
        drain();
        write_reg(REG_VP_DIMS, 64'hdead_beef_ffff_ffff);
        send_point({32'h0003_0000, 32'h1234_5678, 32'h8765_4321});
        send_point({32'h0, 32'h0, 32'h0});
        drain();

        // random phases with fresh registers; phase 0 runs without idling
        for (int ph = 0; ph < 9; ph++) begin
            for (int r = 0; r < NUM_REGS; r++) begin
                if ($urandom_range(3) == 0)
                    write_reg(r[IDX_W-1:0], {rand_q(), rand_q()});
                else
                    write_reg(r[IDX_W-1:0], {$urandom, $urandom});
            end
            if (ph % 3 == 1)
                write_reg(REG_W_XY, 64'd0);
            idle_pct_in  = (ph == 0) ? 0 : 34;
            idle_pct_out = (ph == 0) ? 0 : 34;
            if (ph == 2) hold_off = 1'b1;
            for (int n = 0; n < 200; n++) begin
                pt = {rand_coord(), rand_coord(), rand_coord()};
                if (ph % 3 == 1 && $urandom_range(3) == 0) pt[95:64] = '0;
                send_point(pt);
            end
            drain();
        end
        drain();
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // long hold-off on the screen side, counted here, while points keep coming
    initial begin
        wait (hold_off);
        repeat (300) @(posedge i_clk);
        hold_off = 1'b0;
    end
endmodule
